/* rtl/core/rypd_pkg.sv */
package rypd_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int UNIT_SHIFT = 30;
  localparam int ANG_W = 36;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 36'sd1073741824;
  localparam logic signed [ANG_W-1:0] INV_GAIN = 36'sd652032874;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    begin
      case (i)
        5'd0: r = 36'sd536870912;
        5'd1: r = 36'sd316933406;
        5'd2: r = 36'sd167458907;
        5'd3: r = 36'sd85004756;
        5'd4: r = 36'sd42667331;
        5'd5: r = 36'sd21354465;
        5'd6: r = 36'sd10679838;
        5'd7: r = 36'sd5340245;
        5'd8: r = 36'sd2670163;
        5'd9: r = 36'sd1335087;
        5'd10: r = 36'sd667544;
        5'd11: r = 36'sd333772;
        5'd12: r = 36'sd166886;
        5'd13: r = 36'sd83443;
        5'd14: r = 36'sd41722;
        5'd15: r = 36'sd20861;
        5'd16: r = 36'sd10430;
        5'd17: r = 36'sd5215;
        5'd18: r = 36'sd2608;
        5'd19: r = 36'sd1304;
        5'd20: r = 36'sd652;
        5'd21: r = 36'sd326;
        5'd22: r = 36'sd163;
        5'd23: r = 36'sd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/core/rypd_if.sv */
interface rypd_in_if #(
  parameter int POSITION_WIDTH = 32,
  parameter int QUAT_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [POSITION_WIDTH-1:0] reference_x;
  logic signed [POSITION_WIDTH-1:0] reference_y;
  logic signed [QUAT_WIDTH-1:0] reference_qx;
  logic signed [QUAT_WIDTH-1:0] reference_qy;
  logic signed [QUAT_WIDTH-1:0] reference_qz;
  logic signed [QUAT_WIDTH-1:0] reference_qw;
  logic signed [POSITION_WIDTH-1:0] target_x;
  logic signed [POSITION_WIDTH-1:0] target_y;
  logic signed [QUAT_WIDTH-1:0] target_qx;
  logic signed [QUAT_WIDTH-1:0] target_qy;
  logic signed [QUAT_WIDTH-1:0] target_qz;
  logic signed [QUAT_WIDTH-1:0] target_qw;
  modport source (output valid, reference_x, reference_y, reference_qx, reference_qy,
                  reference_qz, reference_qw, target_x, target_y, target_qx, target_qy,
                  target_qz, target_qw, input ready);
  modport sink (input valid, reference_x, reference_y, reference_qx, reference_qy,
                reference_qz, reference_qw, target_x, target_y, target_qx, target_qy,
                target_qz, target_qw, output ready);
endinterface

interface rypd_out_if #(
  parameter int POSITION_WIDTH = 32,
  parameter int QUAT_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [POSITION_WIDTH:0] delta_x;
  logic signed [POSITION_WIDTH:0] delta_y;
  logic signed [QUAT_WIDTH-1:0] yaw_quat_z;
  logic signed [QUAT_WIDTH-1:0] yaw_quat_w;
  modport source (output valid, delta_x, delta_y, yaw_quat_z, yaw_quat_w, input ready);
  modport sink (input valid, delta_x, delta_y, yaw_quat_z, yaw_quat_w, output ready);
endinterface

/* rtl/core/relative_yaw_pose_delta.sv */
// channel  dir  payload
// in       in   reference/target x,y (POSITION_WIDTH), qx..qw (QUAT_WIDTH)
// out      out  delta_x, delta_y (POSITION_WIDTH+1), yaw_quat_z, yaw_quat_w
// One beat per cycle unless stalled; the path runs through the yaw prep, the vectoring
// and rotation CORDIC chains, N = min(CORDIC_STAGES, 24) each, and the output register.
// Synchronous rst clears only the valid bits.
// The whole pipe advances when the output register is empty or taken;
// a stall freezes every stage.
module relative_yaw_pose_delta #(
  parameter int POSITION_WIDTH = 32,
  parameter int QUAT_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input logic clk,
  input logic rst,
  rypd_in_if.sink  in,
  rypd_out_if.source out
);
  import rypd_pkg::*;
  localparam int N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int LAT = 2 * N + 4;
  localparam int SH = UNIT_SHIFT - (QUAT_WIDTH - 1);
  localparam int PD = POSITION_WIDTH + 1;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !out.valid || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out.valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in.valid};
      out.valid <= vld[LAT-1];
    end
  end

  logic signed [PD-1:0] dx_d [LAT];
  logic signed [PD-1:0] dy_d [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      dx_d[0] <= PD'(in.target_x) - PD'(in.reference_x);
      dy_d[0] <= PD'(in.target_y) - PD'(in.reference_y);
      for (int k = 1; k < LAT; k++) begin
        dx_d[k] <= dx_d[k-1];
        dy_d[k] <= dy_d[k-1];
      end
    end
  end

  logic signed [63:0] num [2];
  logic signed [63:0] den [2];
  logic lock [2];
  logic signed [63:0] vx [2][N+1];
  logic signed [63:0] vy [2][N+1];
  logic signed [ANG_W-1:0] va [2][N+1];
  logic lk [2][N+1];

  rypd_yaw_prep #(.QUAT_WIDTH(QUAT_WIDTH)) u_prep_r (
    .clk(clk), .en(en), .qx(in.reference_qx), .qy(in.reference_qy),
    .qz(in.reference_qz), .qw(in.reference_qw),
    .num(num[0]), .den(den[0]), .lock(lock[0]));
  rypd_yaw_prep #(.QUAT_WIDTH(QUAT_WIDTH)) u_prep_t (
    .clk(clk), .en(en), .qx(in.target_qx), .qy(in.target_qy),
    .qz(in.target_qz), .qw(in.target_qw),
    .num(num[1]), .den(den[1]), .lock(lock[1]));

  for (genvar p = 0; p < 2; p++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        lk[p][0] <= lock[p];
        if (den[p] < 0 && num[p] >= 0) begin
          vx[p][0] <= num[p]; vy[p][0] <= -den[p]; va[p][0] <= QUARTER_TURN;
        end else if (den[p] < 0) begin
          vx[p][0] <= -num[p]; vy[p][0] <= den[p]; va[p][0] <= -QUARTER_TURN;
        end else begin
          vx[p][0] <= den[p]; vy[p][0] <= num[p]; va[p][0] <= '0;
        end
      end
    end
    for (genvar i = 0; i < N; i++) begin : g_st
      rypd_cordic_stage #(.W(64), .IDX(i), .ROTATE(1'b0)) u_st (
        .clk(clk), .en(en), .xi(vx[p][i]), .yi(vy[p][i]), .ai(va[p][i]),
        .xo(vx[p][i+1]), .yo(vy[p][i+1]), .ao(va[p][i+1]));
      always_ff @(posedge clk) begin
        if (en) lk[p][i+1] <= lk[p][i];
      end
    end
  end

  logic signed [ANG_W-1:0] ya, yb, dd, h;
  logic signed [ANG_W-1:0] rx [N+1];
  logic signed [ANG_W-1:0] ry [N+1];
  logic signed [ANG_W-1:0] ra [N+1];
  assign ya = lk[0][N] ? '0 : va[0][N];
  assign yb = lk[1][N] ? '0 : va[1][N];
  assign dd = yb - ya;
  assign h = dd >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      if (h > QUARTER_TURN) begin
        rx[0] <= '0; ry[0] <= INV_GAIN; ra[0] <= h - QUARTER_TURN;
      end else if (h < -QUARTER_TURN) begin
        rx[0] <= '0; ry[0] <= -INV_GAIN; ra[0] <= h + QUARTER_TURN;
      end else begin
        rx[0] <= INV_GAIN; ry[0] <= '0; ra[0] <= h;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    rypd_cordic_stage #(.W(ANG_W), .IDX(i), .ROTATE(1'b1)) u_st (
      .clk(clk), .en(en), .xi(rx[i]), .yi(ry[i]), .ai(ra[i]),
      .xo(rx[i+1]), .yo(ry[i+1]), .ao(ra[i+1]));
  end

  function automatic logic signed [QUAT_WIDTH-1:0] to_q(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    logic signed [ANG_W-1:0] hi;
    begin
      hi = (ANG_W'(1) <<< (QUAT_WIDTH - 1)) - 1;
      r = (v + (ANG_W'(1) <<< (SH - 1))) >>> SH;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r[QUAT_WIDTH-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out.delta_x <= dx_d[LAT-1];
      out.delta_y <= dy_d[LAT-1];
      out.yaw_quat_z <= to_q(ry[N]);
      out.yaw_quat_w <= to_q(rx[N]);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.yaw_quat_w))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in.ready == (!out.valid || out.ready))
    else $error("ready mismatch");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-1] |=> out.valid)
    else $error("beat lost");
endmodule

/* rtl/core/rypd_yaw_prep.sv */
module rypd_yaw_prep #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic clk,
  input  logic en,
  input  logic signed [QUAT_WIDTH-1:0] qx,
  input  logic signed [QUAT_WIDTH-1:0] qy,
  input  logic signed [QUAT_WIDTH-1:0] qz,
  input  logic signed [QUAT_WIDTH-1:0] qw,
  output logic signed [63:0] num,
  output logic signed [63:0] den,
  output logic lock
);
  localparam int PW = 2 * QUAT_WIDTH + 3;
  localparam int PRE_SHIFT = 61 - 2 * QUAT_WIDTH;

  logic signed [2*QUAT_WIDTH-1:0] wz, xy, ww, xx, yy, zz, xz, wy;
  logic signed [PW-1:0] n1, d1, l1, m1, la;

  always_ff @(posedge clk) begin
    if (en) begin
      wz <= qw * qz;
      xy <= qx * qy;
      ww <= qw * qw;
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      xz <= qx * qz;
      wy <= qw * qy;
    end
  end

  always_comb begin
    n1 = PW'(wz) + PW'(xy);
    n1 = n1 <<< 1;
    d1 = PW'(ww) + PW'(xx) - PW'(yy) - PW'(zz);
    l1 = (PW'(xz) - PW'(wy)) <<< 1;
    m1 = PW'(ww) + PW'(xx) + PW'(yy) + PW'(zz);
    la = l1[PW-1] ? -l1 : l1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= 64'(n1) <<< PRE_SHIFT;
      den <= 64'(d1) <<< PRE_SHIFT;
      lock <= (la >= m1);
    end
  end
endmodule

/* rtl/core/rypd_cordic_stage.sv */
module rypd_cordic_stage #(
  parameter int W = 64,
  parameter int IDX = 0,
  parameter bit ROTATE = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [W-1:0] xi,
  input  logic signed [W-1:0] yi,
  input  logic signed [rypd_pkg::ANG_W-1:0] ai,
  output logic signed [W-1:0] xo,
  output logic signed [W-1:0] yo,
  output logic signed [rypd_pkg::ANG_W-1:0] ao
);
  import rypd_pkg::*;
  logic up;
  logic signed [ANG_W-1:0] at;

  always_comb begin
    at = atan_lut(5'(IDX));
    up = ROTATE ? !ai[ANG_W-1] : !yi[W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (up == ROTATE) begin
        xo <= xi - (yi >>> IDX);
        yo <= yi + (xi >>> IDX);
      end else begin
        xo <= xi + (yi >>> IDX);
        yo <= yi - (xi >>> IDX);
      end
      ao <= (up ^ ROTATE) ? ai + at : ai - at;
    end
  end
endmodule
